// ===== rtl/core/ubpo_pkg.sv =====
// ----------------------------------------------------------------------------
// ubpo_pkg
// Shared types and constants of the UTF-8 byte-plus-one word unpacker.
// ----------------------------------------------------------------------------
package ubpo_pkg;

  localparam int COUNT_W = 21;
  localparam int INDEX_W = 20;
  localparam int WORD_W  = 32;
  localparam int UNIT_W  = 11;
  localparam int ACC_W   = 24;

  localparam logic [COUNT_W-1:0] MAX_ELEMENTS = 21'd1048576;
  localparam logic [7:0]         LEAD_MIN     = 8'hC2;
  localparam logic [7:0]         LEAD_MAX     = 8'hDF;
  localparam logic [1:0]         CONT_TAG     = 2'b10;
  localparam logic [UNIT_W-1:0]  UNIT_MAX     = 11'd256;
  localparam logic [1:0]         LAST_POS     = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_OVER     = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  word_value;
    logic [INDEX_W-1:0]        word_index;
    logic                      is_status;
    status_t                   status;
    logic [COUNT_W-1:0]        element_count;
  } result_t;

endpackage

// ===== rtl/core/ubpo_if.sv =====
// ----------------------------------------------------------------------------
// ubpo_if
// Valid/ready channel interfaces for the input, result and configuration beats.
// ----------------------------------------------------------------------------
interface ubpo_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel_byte;
  logic       closes;

  modport source (output valid, output channel_byte, output closes, input ready);
  modport sink (input valid, input channel_byte, input closes, output ready);
endinterface

interface ubpo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] word_value;
  logic [19:0]        word_index;
  logic               is_status;
  logic [1:0]         status;
  logic [20:0]        element_count;

  modport source (output valid, output word_value, output word_index, output is_status,
                  output status, output element_count, input ready);
  modport sink (input valid, input word_value, input word_index, input is_status,
                input status, input element_count, output ready);
endinterface

interface ubpo_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] expected_count;

  modport source (output valid, output expected_count, input ready);
  modport sink (input valid, input expected_count, output ready);
endinterface

// ===== rtl/core/utf8_byte_plus_one_word_unpacker.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_plus_one_word_unpacker
// Decodes a UTF-8 byte stream of one- and two-byte sequences, turns each unit
// into a byte, packs four bytes into a signed word and reports run status.
//
//   Channel  Direction  Beat carries
//   in_bus   sink       channel_byte, closes
//   out_bus  source     word_value, word_index, is_status, status, element_count
//   cfg_bus  sink       expected_count
//
// One input beat is accepted every cycle while out_bus is not stalled.
// A result is decoded from the beat held in the input register and is loaded into
// the result register, from which out_bus takes it.
// A stall on out_bus holds both registers; in_bus then accepts a beat only
// while the input register is empty.
// Reset clears the run state and sets expected_count to zero.
// cfg_bus is always ready.
// ----------------------------------------------------------------------------
module utf8_byte_plus_one_word_unpacker
  import ubpo_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  ubpo_in_if.sink   in_bus,
  ubpo_out_if.source out_bus,
  ubpo_cfg_if.sink  cfg_bus
);

  logic       advance;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_closes;
  logic       emit;
  result_t    dec_res;
  result_t    out_res;

  assign cfg_bus.ready = 1'b1;

  ubpo_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_ready     (in_bus.ready),
    .in_byte      (in_bus.channel_byte),
    .in_closes    (in_bus.closes),
    .advance      (advance),
    .stage_valid  (stage_valid),
    .stage_byte   (stage_byte),
    .stage_closes (stage_closes)
  );

  ubpo_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_bus.valid && cfg_bus.ready),
    .cfg_count (cfg_bus.expected_count),
    .take      (stage_valid && advance),
    .in_byte   (stage_byte),
    .in_closes (stage_closes),
    .emit      (emit),
    .res       (dec_res)
  );

  ubpo_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (stage_valid && emit),
    .load_res   (dec_res),
    .advance    (advance),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_res    (out_res)
  );

  assign out_bus.word_value    = out_res.word_value;
  assign out_bus.word_index    = out_res.word_index;
  assign out_bus.is_status     = out_res.is_status;
  assign out_bus.status        = out_res.status;
  assign out_bus.element_count = out_res.element_count;

  a_backpressure_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (out_bus.valid && !out_bus.ready))
    else $error("input stalled without a stalled result");

  a_element_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.is_status) |->
      (out_bus.status == ST_OK && out_bus.element_count == '0))
    else $error("element beat carries status fields");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.is_status) |->
      (out_bus.word_value == '0 && out_bus.word_index == '0))
    else $error("status beat carries element fields");

endmodule

// ===== rtl/core/ubpo_in_reg.sv =====
// ----------------------------------------------------------------------------
// ubpo_in_reg
// Input register that holds one accepted beat until the decoder consumes it.
// ----------------------------------------------------------------------------
module ubpo_in_reg
  import ubpo_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_closes,
  input  logic       advance,
  output logic       stage_valid,
  output logic [7:0] stage_byte,
  output logic       stage_closes
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       closes_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r   <= in_byte;
      closes_r <= in_closes;
    end
  end

  assign stage_valid  = valid_r;
  assign stage_byte   = byte_r;
  assign stage_closes = closes_r;

endmodule

// ===== rtl/core/ubpo_decode.sv =====
// ----------------------------------------------------------------------------
// ubpo_decode
// Run state and per-byte decode: UTF-8 units, word assembly, error tracking.
// ----------------------------------------------------------------------------
module ubpo_decode
  import ubpo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_count,
  input  logic               take,
  input  logic [7:0]         in_byte,
  input  logic               in_closes,
  output logic               emit,
  output result_t            res
);

  logic [COUNT_W-1:0] expected_r;
  logic               lead_pending_r, lead_pending_nxt;
  logic [4:0]         lead_low_r, lead_low_nxt;
  logic [1:0]         unit_pos_r, unit_pos_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  status_t            first_err_r, first_err_nxt;

  always_comb begin
    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] unit_m1;
    logic              unit_ok;
    logic              have_unit;
    status_t           stat;

    lead_pending_nxt = lead_pending_r;
    lead_low_nxt     = lead_low_r;
    unit_pos_nxt     = unit_pos_r;
    acc_nxt          = acc_r;
    count_nxt        = count_r;
    first_err_nxt    = first_err_r;
    emit             = 1'b0;
    res              = '0;
    have_unit        = 1'b0;
    stat             = first_err_r;

    unit    = lead_pending_r ? {lead_low_r, in_byte[5:0]} : {3'b000, in_byte};
    unit_m1 = unit - 11'd1;
    unit_ok = (unit != '0) && (unit <= UNIT_MAX);

    if (in_closes) begin
      if (first_err_r == ST_OK) begin
        if (lead_pending_r || unit_pos_r != 2'd0) begin
          stat = ST_BAD;
        end else if (count_r != expected_r) begin
          stat = ST_MISMATCH;
        end
      end
      emit              = 1'b1;
      res.is_status     = 1'b1;
      res.status        = stat;
      res.element_count = count_r;
      lead_pending_nxt  = 1'b0;
      lead_low_nxt      = '0;
      unit_pos_nxt      = '0;
      acc_nxt           = '0;
      count_nxt         = '0;
      first_err_nxt     = ST_OK;
    end else if (first_err_r == ST_OK) begin
      if (lead_pending_r) begin
        lead_pending_nxt = 1'b0;
        if (in_byte[7:6] != CONT_TAG) begin
          first_err_nxt = ST_BAD;
        end else begin
          have_unit = 1'b1;
        end
      end else if (!in_byte[7]) begin
        have_unit = 1'b1;
      end else if (in_byte >= LEAD_MIN && in_byte <= LEAD_MAX) begin
        lead_pending_nxt = 1'b1;
        lead_low_nxt     = in_byte[4:0];
      end else begin
        first_err_nxt = ST_BAD;
      end

      if (have_unit) begin
        if (!unit_ok) begin
          first_err_nxt = ST_BAD;
        end else if (unit_pos_r != LAST_POS) begin
          acc_nxt      = {acc_r[15:0], unit_m1[7:0]};
          unit_pos_nxt = unit_pos_r + 2'd1;
        end else begin
          unit_pos_nxt = '0;
          if (count_r >= MAX_ELEMENTS) begin
            first_err_nxt = ST_OVER;
          end else begin
            emit           = 1'b1;
            res.word_value = $signed({acc_r, unit_m1[7:0]});
            res.word_index = count_r[INDEX_W-1:0];
            acc_nxt        = '0;
            count_nxt      = count_r + 21'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r     <= '0;
      lead_pending_r <= 1'b0;
      lead_low_r     <= '0;
      unit_pos_r     <= '0;
      acc_r          <= '0;
      count_r        <= '0;
      first_err_r    <= ST_OK;
    end else begin
      if (cfg_write) begin
        expected_r <= cfg_count;
      end
      if (take) begin
        lead_pending_r <= lead_pending_nxt;
        lead_low_r     <= lead_low_nxt;
        unit_pos_r     <= unit_pos_nxt;
        acc_r          <= acc_nxt;
        count_r        <= count_nxt;
        first_err_r    <= first_err_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/ubpo_out_reg.sv =====
// ----------------------------------------------------------------------------
// ubpo_out_reg
// Result register that holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module ubpo_out_reg
  import ubpo_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_valid,
  input  result_t load_res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign advance   = !valid_r || out_ready;
  assign valid_nxt = advance ? load_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
